FILE: rtl/cdsa_pkg.sv
// Shared types and constants for the circular data stack ALU.
// Used by every module of the block and by its port checker.
package cdsa_pkg;

    localparam int VALUE_W = 32;
    localparam int LIT_W   = 32;
    localparam int ACT_W   = 4;

    typedef enum logic [ACT_W-1:0] {
        A_PUSH     = 4'd0,
        A_DUP      = 4'd1,
        A_DROP     = 4'd2,
        A_BACK     = 4'd3,
        A_SWAP     = 4'd4,
        A_OVER     = 4'd5,
        A_ADD      = 4'd6,
        A_AND      = 4'd7,
        A_OR       = 4'd8,
        A_XOR      = 4'd9,
        A_INVERT   = 4'd10,
        A_NEGATE   = 4'd11,
        A_EMIT     = 4'd12,
        A_EMIT_ALL = 4'd13
    } t_action;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [LIT_W-1:0] literal;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      emitted;
        logic                      last;
    } t_out;

    // classification made by the front end, carried through the queue
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             emit_all;
        logic             read_up;
        logic             dual_write;
    } t_cls;

    localparam int CLS_W = $bits(t_cls);

endpackage

FILE: rtl/cdsa_front.sv
// Front end: accepts commands, classifies the action and fits the literal.
// Depends on cdsa_pkg; feeds cdsa_queue.
module cdsa_front import cdsa_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  start,
    input  t_in                   i_item,
    input  logic                  i_full,
    output logic                  busy,
    output logic                  o_push,
    output t_cls                  o_cls,
    output logic [WORD_WIDTH-1:0] o_lit
);

    assign busy   = i_full;
    assign o_push = start && !i_full;

    always_comb begin
        o_cls            = '0;
        o_cls.action     = i_item.action;
        o_cls.emit_all   = (i_item.action == A_EMIT_ALL);
        o_cls.read_up    = (i_item.action == A_BACK);
        o_cls.dual_write = (i_item.action == A_SWAP);
    end

    generate
        if (WORD_WIDTH <= LIT_W) begin : g_lit_cut
            assign o_lit = i_item.literal[WORD_WIDTH-1:0];
        end else begin : g_lit_ext
            assign o_lit = {{(WORD_WIDTH-LIT_W){i_item.literal[LIT_W-1]}}, i_item.literal};
        end
    endgenerate

endmodule

FILE: rtl/cdsa_queue.sv
// Two-entry command queue between the front end and the execution back end.
// Depends on cdsa_pkg only for the house import convention.
module cdsa_queue import cdsa_pkg::*; #(
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int QDEPTH = 2;

    logic [DATA_W-1:0] r_mem [QDEPTH];
    logic              r_wp, n_wp;
    logic              r_rp, n_rp;
    logic [1:0]        r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/cdsa_back.sv
// Back end: stack store, pointer, ALU and emit sequencer.
// Depends on cdsa_pkg; takes commands from cdsa_queue.
module cdsa_back import cdsa_pkg::*; #(
    parameter int STACK_DEPTH = 8,
    parameter int WORD_WIDTH  = 32,
    parameter int DATA_W      = CLS_W + WORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [DATA_W-1:0] i_q_data,
    output logic              o_q_pop,
    output logic              o_strobe,
    output t_out              o_result
);

    localparam int PW = $clog2(STACK_DEPTH);
    localparam logic [PW-1:0] PTR_MAX = PW'(STACK_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WR2  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [WORD_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_valid;

    logic [PW-1:0]         r_ptr, n_ptr;
    logic [PW-1:0]         r_cnt, n_cnt;
    t_cls                  r_cls;
    logic [WORD_WIDTH-1:0] r_lit;
    logic [WORD_WIDTH-1:0] r_hold, n_hold;
    logic [WORD_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                  r_va, r_vb;
    logic                  r_stb, n_stb;
    t_out                  r_out;

    t_cls                  q_cls;
    logic [PW-1:0]         ptr_up, ptr_dn, addr_a;
    logic [WORD_WIDTH-1:0] a, b;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic [WORD_WIDTH-1:0] res_word;
    logic [VALUE_W-1:0]    res_value;
    logic                  res_emitted, res_last;

    assign q_cls  = t_cls'(i_q_data[DATA_W-1 -: CLS_W]);
    assign ptr_up = (r_ptr == PTR_MAX) ? '0 : r_ptr + 1'b1;
    assign ptr_dn = (r_ptr == '0) ? PTR_MAX : r_ptr - 1'b1;
    assign a      = r_va ? r_rd_a : '0;
    assign b      = r_vb ? r_rd_b : '0;

    assign o_q_pop = r_state[0] && i_q_valid;
    assign addr_a  = (r_state == S_IDLE && q_cls.read_up) ? ptr_up :
                     (r_state == S_IDLE) ? r_ptr : ptr_dn;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_hold      = r_hold;
        n_stb       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_data     = a;
        res_word    = a;
        res_emitted = 1'b0;
        res_last    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_stb   = 1'b1;
                n_state = S_IDLE;
                unique case (r_cls.action)
                    A_PUSH: begin
                        wr_en = 1'b1; wr_addr = ptr_up; wr_data = r_lit;
                        n_ptr = ptr_up; res_word = r_lit;
                    end
                    A_DUP: begin
                        wr_en = 1'b1; wr_addr = ptr_up; wr_data = a;
                        n_ptr = ptr_up; res_word = a;
                    end
                    A_DROP: begin
                        n_ptr = ptr_dn; res_word = b;
                    end
                    A_BACK: begin
                        n_ptr = ptr_up; res_word = a;
                    end
                    A_SWAP: begin
                        wr_en = 1'b1; wr_addr = r_ptr; wr_data = b;
                        n_hold = a; res_word = b;
                    end
                    A_OVER: begin
                        wr_en = 1'b1; wr_addr = ptr_up; wr_data = b;
                        n_ptr = ptr_up; res_word = b;
                    end
                    A_ADD, A_AND, A_OR, A_XOR: begin
                        priority case (r_cls.action)
                            A_ADD:   wr_data = a + b;
                            A_AND:   wr_data = a & b;
                            A_OR:    wr_data = a | b;
                            default: wr_data = a ^ b;
                        endcase
                        wr_en = 1'b1; wr_addr = ptr_dn;
                        n_ptr = ptr_dn; res_word = wr_data;
                    end
                    A_INVERT: begin
                        wr_en = 1'b1; wr_data = ~a; res_word = ~a;
                    end
                    A_NEGATE: begin
                        wr_en = 1'b1; wr_data = '0 - a; res_word = '0 - a;
                    end
                    A_EMIT: begin
                        n_ptr = ptr_dn; res_emitted = 1'b1;
                    end
                    A_EMIT_ALL: begin
                        n_ptr = ptr_dn; res_emitted = 1'b1; res_last = 1'b0;
                    end
                    default: begin
                        res_word = a;
                    end
                endcase
                if (r_cls.dual_write) begin
                    n_state = S_WR2;
                end else if (r_cls.emit_all) begin
                    n_state = S_EMIT;
                    n_cnt   = PW'(1);
                end
            end
            S_WR2: begin
                wr_en   = 1'b1;
                wr_addr = ptr_dn;
                wr_data = r_hold;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                n_stb       = 1'b1;
                res_emitted = 1'b1;
                res_last    = (r_cnt == PTR_MAX);
                n_ptr       = ptr_dn;
                n_cnt       = r_cnt + 1'b1;
                if (res_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    generate
        if (WORD_WIDTH >= VALUE_W) begin : g_val_cut
            assign res_value = res_word[VALUE_W-1:0];
        end else begin : g_val_ext
            assign res_value = {{(VALUE_W-WORD_WIDTH){1'b0}}, res_word};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_valid <= '0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_stb   <= n_stb;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cls <= q_cls;
            r_lit <= i_q_data[WORD_WIDTH-1:0];
        end
        r_hold         <= n_hold;
        r_out.value    <= res_value;
        r_out.emitted  <= res_emitted;
        r_out.last     <= res_last;
    end

    // stack store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[ptr_dn];
        r_va   <= r_valid[addr_a];
        r_vb   <= r_valid[ptr_dn];
    end

    assign o_strobe = r_stb;
    assign o_result = r_out;

endmodule

FILE: rtl/circular_data_stack_alu.sv
// Channel   Handshake                Payload
// command   start in, busy out       i_item   (t_in: action, literal)
// result    o_strobe out, no stall   o_result (t_out: value, emitted, last)
//
// A command is taken on a clock edge with start high and busy low, then waits
// in a two-entry queue. The back end takes it in S_IDLE and executes it in
// S_EXEC; swap adds S_WR2 (second write through the single store write port)
// and emit_all adds S_EMIT; the result is registered, shown in the cycle after execution.
// Synchronous active-low reset empties the queue, clears the pointer and marks
// every store entry as zero. busy is high only while the queue is full.
// Top level: front end, command queue, back end. Depends on cdsa_pkg.
module circular_data_stack_alu import cdsa_pkg::*; #(
    parameter int STACK_DEPTH = 8,
    parameter int WORD_WIDTH  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    localparam int DATA_W = CLS_W + WORD_WIDTH;

    logic                  q_full, q_push, q_pop, q_valid;
    t_cls                  f_cls;
    logic [WORD_WIDTH-1:0] f_lit;
    logic [DATA_W-1:0]     q_data;

    cdsa_front #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_front (
        .start (start),
        .i_item(i_item),
        .i_full(q_full),
        .busy  (busy),
        .o_push(q_push),
        .o_cls (f_cls),
        .o_lit (f_lit)
    );

    cdsa_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data ({f_cls, f_lit}),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    cdsa_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .DATA_W     (DATA_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_data),
        .o_q_pop  (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: rtl/cdsa_checker.sv
// Port-level checks for circular_data_stack_alu, bound to the top level.
// Depends on cdsa_pkg.
module cdsa_checker import cdsa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_strobe,
    input t_out o_result
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("strobe or busy right after reset");

    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.emitted |-> o_result.last)
        else $error("non-emitted result without last");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_strobe && o_result.emitted)
        else $error("emit burst broken");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("result right after final transfer");

endmodule

bind circular_data_stack_alu cdsa_checker u_cdsa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);
